/* hw/rtl/aerhs_pkg.sv */
// ----------------------------------------------------------------------------
// aerhs_pkg: shared types and constants for the AER handshake sender
// Field widths, status and kind codes, register indexes, and the structs
// that carry configuration, items and results between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package aerhs_pkg;

    localparam int MAX_DATA_BITS = 32;
    localparam int WORD_W        = 32;
    localparam int WIDTH_W       = 6;
    localparam int DELAY_W       = 8;
    localparam int TIMEOUT_W     = 24;
    localparam int CFG_DATA_W    = 24;
    localparam int CFG_IDX_W     = 3;
    localparam int STATUS_W      = 3;
    localparam int S_TDATA_W     = 40;   // event_word + ack_level, byte padded
    localparam int M_TDATA_W     = 40;   // req + pins + busy + status, byte padded

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(50000);

    // kind of an input beat
    localparam logic KIND_SEND = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_NONE     = 3'd0,
        ST_OK       = 3'd1,
        ST_TIMEOUT  = 3'd2,
        ST_INACTIVE = 3'd3,
        ST_BUSY     = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE     = 3'd0,
        CFG_PIN_COUNT  = 3'd1,
        CFG_EDGE_DELAY = 3'd2,
        CFG_HS_LOW     = 3'd3,
        CFG_DATA_LOW   = 3'd4,
        CFG_TIMEOUT    = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic                 enable;
        logic [WIDTH_W-1:0]   pin_count;
        logic [DELAY_W-1:0]   edge_delay;
        logic                 hs_active_low;
        logic                 data_active_low;
        logic [TIMEOUT_W-1:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic              kind;
        logic [WORD_W-1:0] event_word;
        logic              ack_level;
    } t_item;

    typedef struct packed {
        logic              req_level;
        logic [WORD_W-1:0] data_pin_levels;
        logic              busy_res;
        t_status           status;
    } t_result;

endpackage

`default_nettype wire

/* hw/rtl/aerhs_cfg.sv */
// ----------------------------------------------------------------------------
// aerhs_cfg: configuration register file
// Six write-only registers, written by index; unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module aerhs_cfg
    import aerhs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable          <= 1'b0;
            r_cfg.pin_count       <= '0;
            r_cfg.edge_delay      <= '0;
            r_cfg.hs_active_low   <= 1'b0;
            r_cfg.data_active_low <= 1'b0;
            r_cfg.timeout_ticks   <= TIMEOUT_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_ENABLE:     r_cfg.enable          <= i_cfg_wdata[0];
                CFG_PIN_COUNT:  r_cfg.pin_count       <= i_cfg_wdata[WIDTH_W-1:0];
                CFG_EDGE_DELAY: r_cfg.edge_delay      <= i_cfg_wdata[DELAY_W-1:0];
                CFG_HS_LOW:     r_cfg.hs_active_low   <= i_cfg_wdata[0];
                CFG_DATA_LOW:   r_cfg.data_active_low <= i_cfg_wdata[0];
                CFG_TIMEOUT:    r_cfg.timeout_ticks   <= i_cfg_wdata[TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* hw/rtl/aerhs_core.sv */
// ----------------------------------------------------------------------------
// aerhs_core: handshake sequencer
// Holds the handshake state and computes next state and result for one
// beat in a single pass; state advances when i_step is high.
// ----------------------------------------------------------------------------
`default_nettype none

module aerhs_core
    import aerhs_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_step,
    input  wire t_item i_item,
    input  wire t_cfg  i_cfg,
    output t_result    o_res
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_RISE = 2'd1,
        PH_WAIT = 2'd2,
        PH_FALL = 2'd3
    } t_phase;

    t_phase               r_phase,   n_phase;
    logic [DELAY_W-1:0]   r_delay,   n_delay;
    logic [TIMEOUT_W-1:0] r_wait,    n_wait;
    logic [WORD_W-1:0]    r_pins,    n_pins;
    logic                 r_req,     n_req;
    logic                 r_pending, n_pending;

    logic                 ack;
    logic [WIDTH_W-1:0]   width_cl;
    logic [WORD_W-1:0]    mask;
    logic [DELAY_W-1:0]   delay_dec;
    logic [TIMEOUT_W-1:0] wait_inc;
    logic                 end_wait;
    logic                 timed_out;
    t_status              status;

    always_comb begin
        ack       = i_item.ack_level ^ i_cfg.hs_active_low;
        width_cl  = (i_cfg.pin_count > WIDTH_W'(MAX_DATA_BITS)) ?
                    WIDTH_W'(MAX_DATA_BITS) : i_cfg.pin_count;
        mask      = WORD_W'((33'd1 << width_cl) - 33'd1);
        delay_dec = r_delay - DELAY_W'(1);
        wait_inc  = r_wait + TIMEOUT_W'(1);

        n_phase   = r_phase;
        n_delay   = r_delay;
        n_wait    = r_wait;
        n_pins    = r_pins;
        n_req     = r_req;
        n_pending = r_pending;
        end_wait  = 1'b0;
        timed_out = 1'b0;
        status    = ST_NONE;

        if (i_item.kind == KIND_SEND) begin
            if (!i_cfg.enable) begin
                status = ST_INACTIVE;
            end else if (r_phase != PH_IDLE) begin
                status = ST_BUSY;
            end else begin
                n_pins    = (i_item.event_word & mask) ^
                            (i_cfg.data_active_low ? mask : '0);
                n_pending = 1'b0;
                n_delay   = i_cfg.edge_delay;
                if (i_cfg.edge_delay == '0) begin
                    n_req   = 1'b1;
                    n_wait  = '0;
                    n_phase = PH_WAIT;
                end else begin
                    n_phase = PH_RISE;
                end
            end
        end else begin
            unique case (r_phase)
                PH_RISE: begin
                    n_delay = delay_dec;
                    if (delay_dec == '0) begin
                        n_req   = 1'b1;
                        n_wait  = '0;
                        n_phase = PH_WAIT;
                    end
                end
                PH_WAIT: begin
                    if (ack) begin
                        end_wait = 1'b1;
                    end else begin
                        n_wait = wait_inc;
                        if (wait_inc >= i_cfg.timeout_ticks) begin
                            end_wait  = 1'b1;
                            timed_out = 1'b1;
                        end
                    end
                end
                PH_FALL: begin
                    n_delay = delay_dec;
                    if (delay_dec == '0) begin
                        n_req   = 1'b0;
                        n_phase = PH_IDLE;
                        status  = r_pending ? ST_TIMEOUT : ST_OK;
                    end
                end
                PH_IDLE: ;
            endcase

            // end of the ACK wait: hold REQ for another delay, or drop it now
            if (end_wait) begin
                n_pending = timed_out;
                n_delay   = i_cfg.edge_delay;
                if (i_cfg.edge_delay == '0) begin
                    n_req   = 1'b0;
                    n_phase = PH_IDLE;
                    status  = timed_out ? ST_TIMEOUT : ST_OK;
                end else begin
                    n_phase = PH_FALL;
                end
            end
        end

        o_res.req_level       = n_req ^ i_cfg.hs_active_low;
        o_res.data_pin_levels = n_pins;
        o_res.busy_res        = (n_phase != PH_IDLE);
        o_res.status          = status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_delay   <= '0;
            r_wait    <= '0;
            r_pins    <= '0;
            r_req     <= 1'b0;
            r_pending <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_delay   <= n_delay;
            r_wait    <= n_wait;
            r_pins    <= n_pins;
            r_req     <= n_req;
            r_pending <= n_pending;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/aer_handshake_sender.sv */
// ----------------------------------------------------------------------------
// aer_handshake_sender: one channel of an address-event REQ/ACK transmitter
//
// Input stream (s side): each beat is either a send request (tuser = 0),
// carrying the event word, or a clock tick (tuser = 1), carrying the raw
// ACK pin sample. Every input beat yields exactly one output beat (m side)
// with the raw REQ level, the raw data pin levels, the busy flag and a
// status code (none, done ok, timeout, not active, rejected busy).
// Configuration is a write-only register port (enable, data width, REQ
// delay, handshake polarity, data polarity, timeout); write it only while
// the stream is quiet.
// Path: input register, then result register. Throughput: one beat per
// cycle while the receiver keeps tready high; the handshake state update
// is a single combinational pass between the two registers.
// Stall: when the receiver holds tready low the result register holds,
// one more beat is parked in the input register, and then s tready drops.
// Reset: both stages empty, registers to defaults (timeout 50000), REQ
// deasserted, data pins 0, channel idle.
// ----------------------------------------------------------------------------
`default_nettype none

module aer_handshake_sender
    import aerhs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input stream
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [S_TDATA_W-1:0]  i_s_tdata,   // [31:0] event_word, [32] ack_level
    input  wire logic                  i_s_tuser,   // [0] kind
    // result stream
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]       o_m_tdata,   // [0] req_level, [32:1] data_pin_levels,
                                                    // [33] busy_res, [36:34] status
    // configuration
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg    cfg;
    t_result core_res;
    logic    advance;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_out;

    aerhs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // a beat moves from the input register into the result register
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    aerhs_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_item  (r_item),
        .i_cfg   (cfg),
        .o_res   (core_res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_item.kind       <= i_s_tuser;
            r_item.event_word <= i_s_tdata[WORD_W-1:0];
            r_item.ack_level  <= i_s_tdata[WORD_W];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_m_tready) begin
            r_out_valid <= r_in_valid;
        end
        if (advance) begin
            r_out <= core_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(M_TDATA_W - STATUS_W - WORD_W - 2)'(0),
                         r_out.status, r_out.busy_res,
                         r_out.data_pin_levels, r_out.req_level};

endmodule

`default_nettype wire

/* hw/rtl/aerhs_checker.sv */
// ----------------------------------------------------------------------------
// aerhs_checker: port-level checks for the AER handshake sender
// Watches the top level's ports only; attached by the bind below.
// ----------------------------------------------------------------------------
`default_nettype none

module aerhs_checker
    import aerhs_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_m_tvalid,
    input wire logic                 i_m_tready,
    input wire logic [M_TDATA_W-1:0] o_m_tdata
);

    logic [STATUS_W-1:0] st;
    logic                busy;

    assign st   = o_m_tdata[WORD_W+1+STATUS_W:WORD_W+2];
    assign busy = o_m_tdata[WORD_W+1];

    // stalled result beat keeps its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result beat changed while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // a reported outcome means the handshake is over
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (st == ST_OK || st == ST_TIMEOUT) |-> !busy)
        else $error("outcome reported while still busy");

    // a busy rejection only happens during a handshake
    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && st == ST_BUSY |-> busy)
        else $error("busy rejection while idle");

endmodule

bind aer_handshake_sender aerhs_checker u_aerhs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
